>>> sv/mlp_pkg.sv
// shared types, constants and helper functions of the backprop trainer
package mlp_pkg;

    localparam int MAX_LAYERS      = 4;
    localparam int MAX_NEURONS     = 16;
    localparam int FRAC_BITS       = 16;
    localparam int SIGMOID_ENTRIES = 1024;

    localparam int DATA_W  = 24;
    localparam int OPND_W  = DATA_W + 1;
    localparam int PROD_W  = 2 * OPND_W;
    localparam int ACC_W   = 56;
    localparam int SIG_W   = FRAC_BITS + 1;
    localparam int SIDX_W  = $clog2(SIGMOID_ENTRIES);
    localparam int SIG_SHIFT = FRAC_BITS + 4 - SIDX_W;

    localparam int WROW    = MAX_NEURONS + 1;
    localparam int WLAYER  = MAX_NEURONS * WROW;
    localparam int WDEPTH  = (MAX_LAYERS - 1) * WLAYER;
    localparam int WADDR_W = $clog2(WDEPTH);
    localparam int ADEPTH  = MAX_LAYERS * MAX_NEURONS;
    localparam int DDEPTH  = (MAX_LAYERS - 1) * MAX_NEURONS;
    localparam int TDEPTH  = MAX_NEURONS;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [1:0] OP_WEIGHT  = 2'd0;
    localparam logic [1:0] OP_FEATURE = 2'd1;
    localparam logic [1:0] OP_TARGET  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LAYERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE3      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LRATE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN      = 3'd6;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [OPND_W-1:0] opnd_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;
    typedef logic [SIG_W-1:0]         sig_t;
    typedef sig_t sig_tab_t [SIGMOID_ENTRIES];

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_add;
    } mac_ctrl_t;

    localparam opnd_t ONE = opnd_t'(1) <<< FRAC_BITS;

    function automatic data_t sat24(acc_t v);
        acc_t hi;
        acc_t lo;
        hi = acc_t'({1'b0, {(DATA_W-1){1'b1}}});
        lo = -hi - acc_t'(1);
        if (v > hi) begin
            return data_t'(hi);
        end else if (v < lo) begin
            return data_t'(lo);
        end
        return data_t'(v);
    endfunction

    function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d}) begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic sig_tab_t build_sig();
        sig_tab_t t;
        logic [63:0] m, u, u2, u3, u4, e, den, num;
        longint diff;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            diff = 64'(16 * i) - 64'(8 * SIGMOID_ENTRIES);
            m = (diff < 0) ? 64'(-diff) : 64'(diff);
            e = 64'd1 << 32;
            if (m != 64'd0) begin
                u  = (m << 20) / SIGMOID_ENTRIES;
                u2 = (u * u) >> 32;
                u3 = (u2 * u) >> 32;
                u4 = (u3 * u) >> 32;
                e  = (64'd1 << 32) - u + u2 / 2 - u3 / 6 + u4 / 24;
                for (int r = 0; r < 12; r++) begin
                    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
                    e = (e * e + (64'd1 << 31)) >> 32;
                end
            end
            den = (64'd1 << 32) + e;
            num = (diff >= 0) ? (64'd1 << (FRAC_BITS + 32)) : (e << FRAC_BITS);
            t[i] = SIG_W'(udiv64(num + (den >> 1), den));
        end
        return t;
    endfunction

    localparam sig_tab_t SIG_TABLE = build_sig();

    function automatic logic [WADDR_W-1:0] waddr(logic [1:0] l, logic [3:0] j, logic [4:0] k);
        return WADDR_W'(l) * WADDR_W'(WLAYER) + WADDR_W'(j) * WADDR_W'(WROW) + WADDR_W'(k);
    endfunction

endpackage

>>> sv/mlp_ram.sv
// generic single-port-write, registered-read ram
module mlp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/mlp_mac.sv
// shared multiplier with registered product and wide accumulator
module mlp_mac (
    input  logic               aclk,
    input  mlp_pkg::mac_ctrl_t ctrl,
    input  mlp_pkg::opnd_t     op_a,
    input  mlp_pkg::opnd_t     op_b,
    output mlp_pkg::prod_t     prod,
    output mlp_pkg::acc_t      acc
);
    import mlp_pkg::*;

    prod_t prod_reg;
    acc_t  acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + acc_t'(prod_reg);
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;
endmodule

>>> sv/mlp_backprop_trainer.sv
// top level: sequencer, stores and stream ports of the backprop trainer
//
// Words are taken one at a time and s_tready is high only while the block is
// idle. A feature or target word, or a weight word with a nonzero layer and a
// source index of at most 16, is stored in the cycle it is taken. A closing
// feature word (inference) or target word (training) starts a pass through
// one shared multiply-accumulate unit: the weighted sums, bias included, and
// the activation of each neuron, in training the error of each output neuron,
// each result word, which may stall on the output, and in training the output
// deltas, the hidden deltas and the weight update. After reset the weight
// store is cleared one word a cycle, all 816 words, before the first word is
// accepted.
module mlp_backprop_trainer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // weight_layer, neuron_index, source_index, data_value, zero fill
    input  logic [mlp_pkg::S_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic [1:0]                       s_tuser,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // output_index, output_value, half_squared_error, zero fill
    output logic [mlp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [mlp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mlp_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import mlp_pkg::*;

    typedef enum logic [31:0] {
        ST_CLEAR = 32'd1 << 0,  ST_IDLE  = 32'd1 << 1,
        ST_F_RD  = 32'd1 << 2,  ST_F_MUL = 32'd1 << 3,
        ST_F_ACC = 32'd1 << 4,  ST_F_SAT = 32'd1 << 5,
        ST_F_SIG = 32'd1 << 6,  ST_F_WR  = 32'd1 << 7,
        ST_E_RD  = 32'd1 << 8,  ST_E_DIF = 32'd1 << 9,
        ST_E_MUL = 32'd1 << 10, ST_E_ACC = 32'd1 << 11,
        ST_O_RD  = 32'd1 << 12, ST_O_LD  = 32'd1 << 13,
        ST_O_WAIT = 32'd1 << 14, ST_D_RD = 32'd1 << 15,
        ST_D_P   = 32'd1 << 16, ST_D_PM  = 32'd1 << 17,
        ST_D_WR  = 32'd1 << 18, ST_H_RD  = 32'd1 << 19,
        ST_H_MUL = 32'd1 << 20, ST_H_ACC = 32'd1 << 21,
        ST_H_ORD = 32'd1 << 22, ST_H_P   = 32'd1 << 23,
        ST_H_PM  = 32'd1 << 24, ST_H_WR  = 32'd1 << 25,
        ST_U_RD  = 32'd1 << 26, ST_U_BD  = 32'd1 << 27,
        ST_U_BDR = 32'd1 << 28, ST_U_WRD = 32'd1 << 29,
        ST_U_MUL = 32'd1 << 30, ST_U_WR  = 32'd1 << 31
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [2:0]  num_layers_reg;
    logic [4:0]  size_reg [MAX_LAYERS];
    logic [15:0] lrate_reg;
    logic        train_reg;

    // sequencer
    logic [1:0]         lay_reg, lay_next;
    logic [3:0]         j_reg, j_next;
    logic [4:0]         k_reg, k_next;
    logic [WADDR_W-1:0] clr_reg, clr_next;
    logic               training_reg, training_next;
    data_t              sum_reg, sum_next;
    sig_t               sig_reg, sig_next;
    opnd_t              diff_reg, diff_next;
    opnd_t              bd_reg, bd_next;
    data_t              wq_reg, wq_next;
    logic [31:0]        hse_reg, hse_next;
    logic [3:0]         oidx_reg, oidx_next;
    sig_t               oval_reg, oval_next;
    logic               olast_reg, olast_next;
    logic               mvalid_reg, mvalid_next;

    // input fields
    logic [1:0] in_op, in_wl;
    logic [3:0] in_ni;
    logic [4:0] in_si;
    data_t      in_data;
    logic       in_acc;

    // sizes
    logic [4:0] size_eff [MAX_LAYERS];
    logic [2:0] nl;
    logic [1:0] ol, lay_m1, lay_p1;
    logic [4:0] ps, cs, nsz, os;
    logic [4:0] j_inc, k_inc;

    // mac
    mac_ctrl_t mac_ctrl;
    opnd_t     op_a, op_b;
    prod_t     prod;
    acc_t      acc;
    opnd_t     act_x, delta_x, w_x, p_x;

    // rams
    logic                     w_we, a_we, d_we, t_we;
    logic [WADDR_W-1:0]       w_waddr, w_raddr;
    logic [$clog2(ADEPTH)-1:0] a_waddr, a_raddr;
    logic [$clog2(DDEPTH)-1:0] d_waddr, d_raddr;
    logic [$clog2(TDEPTH)-1:0] t_waddr, t_raddr;
    data_t w_wdata, a_wdata, d_wdata, w_q, a_q, d_q, t_q;

    // sigmoid index
    logic signed [DATA_W:0] sig_v;
    logic [DATA_W-1:0]      sig_sh;
    logic [SIDX_W-1:0]      sig_idx;

    assign in_op   = s_tuser;
    assign in_wl   = s_tdata[1:0];
    assign in_ni   = s_tdata[5:2];
    assign in_si   = s_tdata[10:6];
    assign in_data = s_tdata[34:11];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc  = s_tvalid && s_tready;

    always_comb begin
        for (int i = 0; i < MAX_LAYERS; i++) begin
            if (size_reg[i] == 5'd0) begin
                size_eff[i] = 5'd1;
            end else if (size_reg[i] > 5'(MAX_NEURONS)) begin
                size_eff[i] = 5'(MAX_NEURONS);
            end else begin
                size_eff[i] = size_reg[i];
            end
        end
        if (num_layers_reg < 3'd2) begin
            nl = 3'd2;
        end else if (num_layers_reg > 3'(MAX_LAYERS)) begin
            nl = 3'(MAX_LAYERS);
        end else begin
            nl = num_layers_reg;
        end
    end

    assign ol     = 2'(nl - 3'd1);
    assign lay_m1 = lay_reg - 2'd1;
    assign lay_p1 = lay_reg + 2'd1;
    assign ps     = size_eff[lay_m1];
    assign cs     = size_eff[lay_reg];
    assign nsz    = size_eff[lay_p1];
    assign os     = size_eff[ol];
    assign j_inc  = {1'b0, j_reg} + 5'd1;
    assign k_inc  = k_reg + 5'd1;

    assign act_x   = opnd_t'(a_q);
    assign delta_x = opnd_t'(d_q);
    assign w_x     = opnd_t'(w_q);
    assign p_x     = prod[FRAC_BITS+OPND_W-1:FRAC_BITS];

    always_comb begin
        sig_v  = {sum_reg[DATA_W-1], sum_reg} + ((DATA_W+1)'(8) <<< FRAC_BITS);
        sig_sh = DATA_W'(sig_v >>> SIG_SHIFT);
        if (sig_v <= 0) begin
            sig_idx = '0;
        end else if (sig_sh >= DATA_W'(SIGMOID_ENTRIES)) begin
            sig_idx = SIDX_W'(SIGMOID_ENTRIES - 1);
        end else begin
            sig_idx = sig_sh[SIDX_W-1:0];
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_layers_reg <= 3'd3;
            for (int i = 0; i < MAX_LAYERS; i++) size_reg[i] <= 5'd16;
            lrate_reg <= 16'd16384;
            train_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NUM_LAYERS: num_layers_reg <= cfg_data[2:0];
                CFG_SIZE0:      size_reg[0] <= cfg_data[4:0];
                CFG_SIZE1:      size_reg[1] <= cfg_data[4:0];
                CFG_SIZE2:      size_reg[2] <= cfg_data[4:0];
                CFG_SIZE3:      size_reg[3] <= cfg_data[4:0];
                CFG_LRATE:      lrate_reg <= cfg_data;
                CFG_TRAIN:      train_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // mac operands and control
    always_comb begin
        op_a = '0;
        op_b = '0;
        mac_ctrl.mul_en  = 1'b0;
        mac_ctrl.acc_add = 1'b0;
        mac_ctrl.acc_clr = (state_reg == ST_IDLE) || (state_reg == ST_F_WR) ||
                           (state_reg == ST_D_WR) || (state_reg == ST_H_WR);
        unique case (state_reg)
            ST_F_MUL: begin
                op_a = (k_reg == ps) ? ONE : act_x;
                op_b = w_x;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_E_MUL: begin
                op_a = diff_reg;
                op_b = diff_reg;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_D_P, ST_H_P: begin
                op_a = act_x;
                op_b = ONE - act_x;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_D_PM: begin
                op_a = p_x;
                op_b = diff_reg;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_H_PM: begin
                op_a = p_x;
                op_b = opnd_t'(sum_reg);
                mac_ctrl.mul_en = 1'b1;
            end
            ST_H_MUL: begin
                op_a = delta_x;
                op_b = w_x;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_U_BD: begin
                op_a = opnd_t'({1'b0, lrate_reg});
                op_b = delta_x;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_U_MUL: begin
                op_a = bd_reg;
                op_b = (k_reg == ps) ? ONE : act_x;
                mac_ctrl.mul_en = 1'b1;
            end
            ST_F_ACC, ST_E_ACC, ST_H_ACC: mac_ctrl.acc_add = 1'b1;
            default: ;
        endcase
    end

    // store ports
    always_comb begin
        w_we = 1'b0; w_waddr = waddr(lay_m1, j_reg, k_reg); w_wdata = '0;
        a_we = 1'b0; a_waddr = {2'd0, in_ni}; a_wdata = in_data;
        d_we = 1'b0; d_waddr = {lay_m1, j_reg};
        d_wdata = sat24(acc_t'(prod) >>> FRAC_BITS);
        t_we = 1'b0; t_waddr = in_ni;
        w_raddr = waddr(lay_m1, j_reg, k_reg);
        a_raddr = {lay_m1, k_reg[3:0]};
        d_raddr = {lay_m1, j_reg};
        t_raddr = j_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                w_we = 1'b1;
                w_waddr = clr_reg;
            end
            ST_IDLE: begin
                if (in_acc && in_op == OP_WEIGHT && in_wl != 2'd0 &&
                        in_si <= 5'(MAX_NEURONS)) begin
                    w_we = 1'b1;
                    w_waddr = waddr(in_wl - 2'd1, in_ni, in_si);
                    w_wdata = in_data;
                end
                a_we = in_acc && (in_op == OP_FEATURE);
                t_we = in_acc && (in_op == OP_TARGET);
            end
            ST_F_WR: begin
                a_we = 1'b1;
                a_waddr = {lay_reg, j_reg};
                a_wdata = data_t'({1'b0, sig_reg});
            end
            ST_E_RD, ST_O_RD, ST_D_RD: a_raddr = {ol, j_reg};
            ST_D_WR: begin
                d_we = 1'b1;
                d_waddr = {ol - 2'd1, j_reg};
            end
            ST_H_RD: begin
                w_raddr = waddr(lay_reg, k_reg[3:0], {1'b0, j_reg});
                d_raddr = {lay_reg, k_reg[3:0]};
            end
            ST_H_ORD: a_raddr = {lay_reg, j_reg};
            ST_H_WR: d_we = 1'b1;
            ST_U_WR: begin
                w_we = 1'b1;
                w_wdata = sat24(acc_t'(wq_reg) + (acc_t'(prod) >>> FRAC_BITS));
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        lay_next      = lay_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        clr_next      = clr_reg;
        training_next = training_reg;
        sum_next      = sum_reg;
        sig_next      = sig_reg;
        diff_next     = diff_reg;
        bd_next       = bd_reg;
        wq_next       = wq_reg;
        hse_next      = hse_reg;
        oidx_next     = oidx_reg;
        oval_next     = oval_reg;
        olast_next    = olast_reg;
        mvalid_next   = mvalid_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + WADDR_W'(1);
                if (clr_reg == WADDR_W'(WDEPTH - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                lay_next = 2'd1;
                j_next   = '0;
                k_next   = '0;
                if (in_acc && s_tlast) begin
                    if (in_op == OP_FEATURE && !train_reg) begin
                        training_next = 1'b0;
                        state_next = ST_F_RD;
                    end else if (in_op == OP_TARGET && train_reg) begin
                        training_next = 1'b1;
                        state_next = ST_F_RD;
                    end
                end
            end
            ST_F_RD:  state_next = ST_F_MUL;
            ST_F_MUL: state_next = ST_F_ACC;
            ST_F_ACC: begin
                if (k_reg == ps) begin
                    state_next = ST_F_SAT;
                end else begin
                    k_next = k_inc;
                    state_next = ST_F_RD;
                end
            end
            ST_F_SAT: begin
                sum_next = sat24(acc >>> FRAC_BITS);
                state_next = ST_F_SIG;
            end
            ST_F_SIG: begin
                sig_next = SIG_TABLE[sig_idx];
                state_next = ST_F_WR;
            end
            ST_F_WR: begin
                k_next = '0;
                if (j_inc < cs) begin
                    j_next = j_inc[3:0];
                    state_next = ST_F_RD;
                end else if ({1'b0, lay_reg} + 3'd1 < nl) begin
                    j_next = '0;
                    lay_next = lay_p1;
                    state_next = ST_F_RD;
                end else begin
                    j_next = '0;
                    state_next = training_reg ? ST_E_RD : ST_O_RD;
                end
            end
            ST_E_RD:  state_next = ST_E_DIF;
            ST_E_DIF: begin
                diff_next = opnd_t'(t_q) - act_x;
                state_next = ST_E_MUL;
            end
            ST_E_MUL: state_next = ST_E_ACC;
            ST_E_ACC: begin
                if (j_inc < os) begin
                    j_next = j_inc[3:0];
                    state_next = ST_E_RD;
                end else begin
                    j_next = '0;
                    state_next = ST_O_RD;
                end
            end
            ST_O_RD: begin
                if (!training_reg) begin
                    hse_next = '0;
                end else if (|acc[ACC_W-1:FRAC_BITS+33]) begin
                    hse_next = '1;
                end else begin
                    hse_next = acc[FRAC_BITS+32:FRAC_BITS+1];
                end
                state_next = ST_O_LD;
            end
            ST_O_LD: begin
                oidx_next   = j_reg;
                oval_next   = a_q[SIG_W-1:0];
                olast_next  = (j_inc == os);
                mvalid_next = 1'b1;
                state_next  = ST_O_WAIT;
            end
            ST_O_WAIT: begin
                if (m_tready) begin
                    mvalid_next = 1'b0;
                    if (olast_reg) begin
                        j_next = '0;
                        state_next = training_reg ? ST_D_RD : ST_IDLE;
                    end else begin
                        j_next = j_inc[3:0];
                        state_next = ST_O_RD;
                    end
                end
            end
            ST_D_RD: state_next = ST_D_P;
            ST_D_P: begin
                diff_next = opnd_t'(t_q) - act_x;
                state_next = ST_D_PM;
            end
            ST_D_PM: state_next = ST_D_WR;
            ST_D_WR: begin
                k_next = '0;
                if (j_inc < os) begin
                    j_next = j_inc[3:0];
                    state_next = ST_D_RD;
                end else if (ol > 2'd1) begin
                    j_next = '0;
                    lay_next = ol - 2'd1;
                    state_next = ST_H_RD;
                end else begin
                    j_next = '0;
                    lay_next = 2'd1;
                    state_next = ST_U_RD;
                end
            end
            ST_H_RD:  state_next = ST_H_MUL;
            ST_H_MUL: state_next = ST_H_ACC;
            ST_H_ACC: begin
                if (k_inc < nsz) begin
                    k_next = k_inc;
                    state_next = ST_H_RD;
                end else begin
                    state_next = ST_H_ORD;
                end
            end
            ST_H_ORD: begin
                sum_next = sat24(acc >>> FRAC_BITS);
                state_next = ST_H_P;
            end
            ST_H_P:  state_next = ST_H_PM;
            ST_H_PM: state_next = ST_H_WR;
            ST_H_WR: begin
                k_next = '0;
                if (j_inc < cs) begin
                    j_next = j_inc[3:0];
                    state_next = ST_H_RD;
                end else if (lay_reg > 2'd1) begin
                    j_next = '0;
                    lay_next = lay_m1;
                    state_next = ST_H_RD;
                end else begin
                    j_next = '0;
                    state_next = ST_U_RD;
                end
            end
            ST_U_RD: state_next = ST_U_BD;
            ST_U_BD: state_next = ST_U_BDR;
            ST_U_BDR: begin
                bd_next = p_x;
                k_next = '0;
                state_next = ST_U_WRD;
            end
            ST_U_WRD: state_next = ST_U_MUL;
            ST_U_MUL: begin
                wq_next = w_q;
                state_next = ST_U_WR;
            end
            ST_U_WR: begin
                if (k_reg != ps) begin
                    k_next = k_inc;
                    state_next = ST_U_WRD;
                end else if (j_inc < cs) begin
                    j_next = j_inc[3:0];
                    state_next = ST_U_RD;
                end else if ({1'b0, lay_reg} + 3'd1 < nl) begin
                    j_next = '0;
                    lay_next = lay_p1;
                    state_next = ST_U_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            mvalid_reg   <= 1'b0;
            training_reg <= 1'b0;
            lay_reg      <= 2'd1;
            j_reg        <= '0;
            k_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            mvalid_reg   <= mvalid_next;
            training_reg <= training_next;
            lay_reg      <= lay_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
        end
        sum_reg   <= sum_next;
        sig_reg   <= sig_next;
        diff_reg  <= diff_next;
        bd_reg    <= bd_next;
        wq_reg    <= wq_next;
        hse_reg   <= hse_next;
        oidx_reg  <= oidx_next;
        oval_reg  <= oval_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {3'd0, hse_reg, oval_reg, oidx_reg};

    mlp_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod),
        .acc  (acc)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(WDEPTH)) u_weight_ram (
        .aclk (aclk), .we (w_we), .waddr (w_waddr), .wdata (w_wdata),
        .raddr (w_raddr), .rdata (w_q)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(ADEPTH)) u_act_ram (
        .aclk (aclk), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
        .raddr (a_raddr), .rdata (a_q)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(DDEPTH)) u_delta_ram (
        .aclk (aclk), .we (d_we), .waddr (d_waddr), .wdata (d_wdata),
        .raddr (d_raddr), .rdata (d_q)
    );

    mlp_ram #(.WIDTH(DATA_W), .DEPTH(TDEPTH)) u_target_ram (
        .aclk (aclk), .we (t_we), .waddr (t_waddr), .wdata (in_data),
        .raddr (t_raddr), .rdata (t_q)
    );
endmodule

>>> tb/tb.sv
// self-checking testbench of the backprop trainer: stream stimulus, predictor and scoreboard
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mlp_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam longint SAT_HI = 64'sd8388607;
    localparam longint SAT_LO = -64'sd8388608;

    typedef struct {
        logic [3:0]  idx;
        logic [16:0] act;
        logic [31:0] hse;
        logic        lst;
    } result_t;

    class trainer_scoreboard;
        result_t pending_q[$];
        int      errors;
        longint  wgt[3][16][17];
        longint  act[4][16];
        longint  dlt[3][16];
        longint  tgt[16];
        int      num_layers;
        int      sizes[4];
        longint  lrate;
        bit      train_on;
        longint unsigned sig_lut[SIGMOID_ENTRIES];

        function new();
            longint unsigned m, u, u2, u3, u4, e, den, num;
            longint diff;
            for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
                diff = 16 * i - 8 * SIGMOID_ENTRIES;
                m = (diff < 0) ? -diff : diff;
                e = 64'd1 << 32;
                if (m != 0) begin
                    u  = (m << 20) / SIGMOID_ENTRIES;
                    u2 = (u * u) >> 32;
                    u3 = (u2 * u) >> 32;
                    u4 = (u3 * u) >> 32;
                    e  = (64'd1 << 32) - u + u2 / 2 - u3 / 6 + u4 / 24;
                    for (int r = 0; r < 12; r++) begin
                        if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
                        e = (e * e + (64'd1 << 31)) >> 32;
                    end
                end
                den = (64'd1 << 32) + e;
                num = (diff >= 0) ? (64'd1 << (FRAC_BITS + 32)) : (e << FRAC_BITS);
                sig_lut[i] = (num + den / 2) / den;
            end
            foreach (wgt[a, b, c]) wgt[a][b][c] = 0;
            foreach (act[a, b]) act[a][b] = 0;
            foreach (dlt[a, b]) dlt[a][b] = 0;
            foreach (tgt[a]) tgt[a] = 0;
            num_layers = 3;
            foreach (sizes[a]) sizes[a] = 16;
            lrate = 16384;
            train_on = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                CFG_NUM_LAYERS: num_layers = val[2:0];
                CFG_SIZE0:      sizes[0] = val[4:0];
                CFG_SIZE1:      sizes[1] = val[4:0];
                CFG_SIZE2:      sizes[2] = val[4:0];
                CFG_SIZE3:      sizes[3] = val[4:0];
                CFG_LRATE:      lrate = val;
                CFG_TRAIN:      train_on = val[0];
                default: ;
            endcase
        endfunction

        function int width_of(int l);
            if (sizes[l] < 1) return 1;
            if (sizes[l] > MAX_NEURONS) return MAX_NEURONS;
            return sizes[l];
        endfunction

        function int depth();
            if (num_layers < 2) return 2;
            if (num_layers > MAX_LAYERS) return MAX_LAYERS;
            return num_layers;
        endfunction

        function longint sat(longint v);
            if (v > SAT_HI) return SAT_HI;
            if (v < SAT_LO) return SAT_LO;
            return v;
        endfunction

        function longint sigmoid(longint s);
            longint v;
            longint idx;
            v = s + (64'sd8 <<< FRAC_BITS);
            idx = 0;
            if (v > 0) idx = (v * SIGMOID_ENTRIES) >>> (FRAC_BITS + 4);
            if (idx >= SIGMOID_ENTRIES) idx = SIGMOID_ENTRIES - 1;
            return longint'(sig_lut[idx]);
        endfunction

        function void forward_pass(int nl);
            longint acc;
            int ps;
            for (int l = 1; l < nl; l++) begin
                ps = width_of(l - 1);
                for (int j = 0; j < width_of(l); j++) begin
                    acc = wgt[l-1][j][ps] <<< FRAC_BITS;
                    for (int k = 0; k < ps; k++) acc += act[l-1][k] * wgt[l-1][j][k];
                    act[l][j] = sigmoid(sat(acc >>> FRAC_BITS));
                end
            end
        endfunction

        function void descend(int nl);
            longint one, o, p, acc, s, bd;
            int ol, ps;
            one = 64'sd1 <<< FRAC_BITS;
            ol = nl - 1;
            for (int j = 0; j < width_of(ol); j++) begin
                o = act[ol][j];
                p = (o * (one - o)) >>> FRAC_BITS;
                dlt[ol-1][j] = sat((p * (tgt[j] - o)) >>> FRAC_BITS);
            end
            for (int l = ol - 1; l > 0; l--) begin
                for (int j = 0; j < width_of(l); j++) begin
                    acc = 0;
                    for (int k = 0; k < width_of(l + 1); k++) acc += dlt[l][k] * wgt[l][k][j];
                    s = sat(acc >>> FRAC_BITS);
                    o = act[l][j];
                    p = (o * (one - o)) >>> FRAC_BITS;
                    dlt[l-1][j] = sat((p * s) >>> FRAC_BITS);
                end
            end
            for (int l = 1; l < nl; l++) begin
                ps = width_of(l - 1);
                for (int j = 0; j < width_of(l); j++) begin
                    bd = (lrate * dlt[l-1][j]) >>> 16;
                    for (int k = 0; k < ps; k++)
                        wgt[l-1][j][k] = sat(wgt[l-1][j][k] + ((bd * act[l-1][k]) >>> FRAC_BITS));
                    wgt[l-1][j][ps] = sat(wgt[l-1][j][ps] + bd);
                end
            end
        endfunction

        function void note_word(logic [1:0] op, logic [1:0] wl, logic [3:0] ni,
                                logic [4:0] si, logic signed [23:0] val, logic lst);
            bit go, learn;
            int nl, os;
            longint sq, e;
            longint unsigned h;
            result_t r;
            go = 0;
            learn = 0;
            case (op)
                OP_WEIGHT: begin
                    if (wl >= 1 && si <= MAX_NEURONS) wgt[wl-1][ni][si] = val;
                end
                OP_FEATURE: begin
                    act[0][ni] = val;
                    go = lst && !train_on;
                end
                OP_TARGET: begin
                    tgt[ni] = val;
                    go = lst && train_on;
                    learn = go;
                end
                default: ;
            endcase
            if (!go) return;
            nl = depth();
            os = width_of(nl - 1);
            forward_pass(nl);
            h = 0;
            if (learn) begin
                sq = 0;
                for (int j = 0; j < os; j++) begin
                    e = tgt[j] - act[nl-1][j];
                    sq += e * e;
                end
                h = longint'(sq) >> (FRAC_BITS + 1);
                if (h > 64'hFFFF_FFFF) h = 64'hFFFF_FFFF;
            end
            for (int j = 0; j < os; j++) begin
                r.idx = 4'(j);
                r.act = 17'(act[nl-1][j]);
                r.hse = 32'(h);
                r.lst = (j + 1 == os);
                pending_q.push_back(r);
            end
            if (learn) descend(nl);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: idx %0d act %0h hse %0h last %0b",
                             got.idx, got.act, got.hse, got.lst);
                return;
            end
            want = pending_q.pop_front();
            if (got.idx !== want.idx || got.act !== want.act ||
                got.hse !== want.hse || got.lst !== want.lst) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: want idx %0d act %0h hse %0h last %0b, got idx %0d act %0h hse %0h last %0b",
                             want.idx, want.act, want.hse, want.lst,
                             got.idx, got.act, got.hse, got.lst);
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    trainer_scoreboard sb = new();
    bit idle_on = 1'b1;
    int words_sent = 0;

    always #1 aclk = ~aclk;

    mlp_backprop_trainer dut (.*);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{m_tdata[3:0], m_tdata[20:4], m_tdata[52:21], m_tlast});
        m_tready <= !idle_on || ($urandom_range(99) >= 28);
    end

    task automatic send_word(logic [1:0] op, logic [1:0] wl, logic [3:0] ni,
                             logic [4:0] si, logic [23:0] val, logic lst);
        while (idle_on && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= lst;
        s_tdata  <= {5'd0, val, si, ni, wl};
        sb.note_word(op, wl, ni, si, val, lst);
        words_sent++;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic configure(int nl, int s0, int s1, int s2, int s3, int lr, int tr);
        int vals[7];
        vals = '{nl, s0, s1, s2, s3, lr, tr};
        wait_drained();
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= CFG_DAT_W'(vals[i]);
            sb.set_reg(CFG_IDX_W'(i), 16'(vals[i]));
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] pick_value(int spread);
        case ($urandom_range(9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(2 * spread)) - spread);
        endcase
    endfunction

    task automatic noise_word();
        case ($urandom_range(3))
            0: send_word(OP_WEIGHT, 2'($urandom), 4'($urandom), 5'($urandom),
                         pick_value(1 << 16), 1'($urandom));
            1: send_word(OP_UNUSED, 2'($urandom), 4'($urandom), 5'($urandom),
                         24'($urandom), 1'($urandom));
            2: if (sb.width_of(0) < 16)
                   send_word(OP_FEATURE, 2'($urandom),
                             4'($urandom_range(15, sb.width_of(0))), 5'($urandom),
                             24'($urandom), 1'b0);
            default: send_word(OP_WEIGHT, 2'($urandom_range(3, 1)), 4'($urandom),
                               5'($urandom_range(16)), pick_value(1 << 17), 1'b0);
        endcase
    endtask

    task automatic load_weights(int cap);
        int nl, n;
        nl = sb.depth();
        n = 0;
        for (int l = 1; l < nl; l++)
            for (int j = 0; j < sb.width_of(l); j++)
                for (int k = 0; k <= sb.width_of(l - 1); k++)
                    if (n < cap) begin
                        send_word(OP_WEIGHT, 2'(l), 4'(j), 5'(k), pick_value(3 << 15),
                                  1'($urandom));
                        n++;
                    end
    endtask

    task automatic run_sample();
        int order[$];
        int n;
        n = sb.width_of(0);
        order.delete();
        for (int i = 0; i < n; i++) order.push_back(i);
        order.shuffle();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 12) noise_word();
            send_word(OP_FEATURE, 2'($urandom), 4'(order[i]), 5'($urandom),
                      pick_value(1 << 18), (i == n - 1) ? 1'b1 : sb.train_on && $urandom_range(1));
        end
        n = sb.width_of(sb.depth() - 1);
        if (!sb.train_on && $urandom_range(1)) n = 0;
        order.delete();
        for (int i = 0; i < n; i++) order.push_back(i);
        order.shuffle();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 12) noise_word();
            send_word(OP_TARGET, 2'($urandom), 4'(order[i]), 5'($urandom),
                      ($urandom_range(9) < 8) ? 24'($urandom_range(65536)) : pick_value(1 << 18),
                      (i == n - 1) ? 1'b1 : !sb.train_on && $urandom_range(1));
        end
    endtask

    initial begin
        int sz[4];
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        configure(3, 2, 2, 2, 16, 65535, 1);
        send_word(OP_WEIGHT, 2'd1, 4'd0, 5'd0, 24'h7FFFFF, 1'b0);
        send_word(OP_WEIGHT, 2'd1, 4'd1, 5'd1, 24'h800000, 1'b0);
        send_word(OP_WEIGHT, 2'd1, 4'd0, 5'd2, 24'h010000, 1'b0);
        send_word(OP_WEIGHT, 2'd2, 4'd1, 5'd0, 24'hFF0000, 1'b0);
        send_word(OP_WEIGHT, 2'd2, 4'd0, 5'd2, 24'h008000, 1'b1);
        send_word(OP_WEIGHT, 2'd0, 4'd0, 5'd0, 24'h123456, 1'b0);
        send_word(OP_WEIGHT, 2'd3, 4'd15, 5'd31, 24'h654321, 1'b0);
        send_word(OP_WEIGHT, 2'd3, 4'd15, 5'd16, 24'hFFFFFF, 1'b0);
        send_word(OP_UNUSED, 2'd3, 4'd15, 5'd31, 24'hFFFFFF, 1'b1);
        send_word(OP_FEATURE, 2'd0, 4'd15, 5'd0, 24'h7FFFFF, 1'b0);
        send_word(OP_FEATURE, 2'd0, 4'd0, 5'd0, 24'h800000, 1'b0);
        send_word(OP_FEATURE, 2'd0, 4'd1, 5'd0, 24'h7FFFFF, 1'b1);
        send_word(OP_TARGET, 2'd0, 4'd0, 5'd0, 24'h000000, 1'b0);
        send_word(OP_TARGET, 2'd0, 4'd1, 5'd0, 24'h010000, 1'b1);
        send_word(OP_TARGET, 2'd0, 4'd1, 5'd0, 24'h800000, 1'b1);
        configure(3, 2, 2, 2, 16, 0, 0);
        send_word(OP_FEATURE, 2'd0, 4'd0, 5'd0, 24'h000000, 1'b1);
        send_word(OP_TARGET, 2'd0, 4'd0, 5'd0, 24'h7FFFFF, 1'b1);

        // clamped register values, then the full-size deep network once
        configure(0, 0, 0, 0, 0, 0, 1);
        load_weights(4);
        run_sample();
        wait_drained();
        configure(7, 31, 31, 31, 31, 65535, 0);
        load_weights(20);
        run_sample();
        configure(4, 16, 16, 16, 16, 32768, 1);
        run_sample();

        idle_on = 1'b0;
        configure(2, 3, 4, 1, 1, 16384, 1);
        load_weights(20);
        repeat (3) run_sample();
        idle_on = 1'b1;

        while (words_sent < 470) begin
            foreach (sz[i]) sz[i] = ($urandom_range(19) == 0) ? 16 : $urandom_range(6, 1);
            configure($urandom_range(4, 2), sz[0], sz[1], sz[2], sz[3],
                      $urandom_range(65535), $urandom_range(9) < 7);
            load_weights($urandom_range(30, 6));
            repeat ($urandom_range(4, 2)) begin
                run_sample();
                if ($urandom_range(5) == 0) wait_drained();
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("[mlp_backprop_trainer] OK");
        end else begin
            $display("[mlp_backprop_trainer] ERROR");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("[mlp_backprop_trainer] ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/mlp_pkg.sv
sv/mlp_ram.sv
sv/mlp_mac.sv
sv/mlp_backprop_trainer.sv
tb/tb.sv
